// File: rtl/crc_pkg.sv
`timescale 1ns / 1ps
// Package: shared types, register map, destination codes and coin window table.
package crc_pkg;

  localparam int unsigned TYPE_SLOTS  = 8;
  localparam int unsigned KNOWN_TYPES = 5;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned APB_AW      = 5;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned COIN_TYPES_DEF = 5;

  // Destination codes
  localparam logic [2:0] DEST_BENT  = 3'd5;
  localparam logic [2:0] DEST_OTHER = 3'd6;

  // Image match code for a full match
  localparam logic [1:0] IMG_BOTH = 2'd0;

  // Register indexes
  localparam logic [2:0] REG_ROLL_NICKEL  = 3'd0;
  localparam logic [2:0] REG_ROLL_DIME    = 3'd1;
  localparam logic [2:0] REG_ROLL_QUARTER = 3'd2;
  localparam logic [2:0] REG_ROLL_LOONIE  = 3'd3;
  localparam logic [2:0] REG_ROLL_TOONIE  = 3'd4;
  localparam logic [2:0] REG_BENT_LIMIT   = 3'd5;
  localparam logic [2:0] REG_OTHER_LIMIT  = 3'd6;

  localparam logic [5:0]  ROLL_RESET [KNOWN_TYPES] = '{6'd40, 6'd50, 6'd40, 6'd25, 6'd25};
  localparam logic [15:0] BENT_LIMIT_RESET  = 16'd2550;
  localparam logic [15:0] OTHER_LIMIT_RESET = 16'd5100;

  // Inclusive windows in raw counts; unused slots are empty (lo > hi)
  localparam logic [7:0] W_LO [TYPE_SLOTS] = '{8'd92, 8'd34, 8'd102, 8'd166, 8'd173,
                                               8'd1, 8'd1, 8'd1};
  localparam logic [7:0] W_HI [TYPE_SLOTS] = '{8'd109, 8'd56, 8'd122, 8'd191, 8'd200,
                                               8'd0, 8'd0, 8'd0};
  localparam logic [7:0] D_LO [TYPE_SLOTS] = '{8'd87, 8'd63, 8'd109, 8'd128, 8'd144,
                                               8'd1, 8'd1, 8'd1};
  localparam logic [7:0] D_HI [TYPE_SLOTS] = '{8'd100, 8'd73, 8'd124, 8'd144, 8'd162,
                                               8'd0, 8'd0, 8'd0};

  typedef struct packed {
    logic [7:0] weight_reading;
    logic [7:0] diameter_reading;
    logic       is_bent;
    logic [1:0] image_match;
  } coin_in_t;

  typedef struct packed {
    logic [2:0]  destination;
    logic [5:0]  wrapper_fill;
    logic        roll_completed;
    logic [15:0] rolls_of_type;
    logic [16:0] container_weight;
    logic        container_replaced;
    logic [15:0] other_coin_total;
    logic [15:0] other_containers_filled;
    logic [15:0] other_in_current;
    logic [31:0] other_weight_total;
  } coin_res_t;

  // Classifier verdict
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } class_t;

  // One wrapper memory entry
  typedef struct packed {
    logic [5:0]  fill;
    logic [15:0] rolls;
  } wrap_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

// File: rtl/crc_chan_if.sv
`timescale 1ns / 1ps
// Interface: valid/ready channel carrying one word of type T.
interface crc_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/crc_classify.sv
`timescale 1ns / 1ps
// Module: window compare of weight and diameter against every coin type.
module crc_classify #(
  parameter int unsigned CoinTypes = crc_pkg::COIN_TYPES_DEF
) (
  input  logic [7:0]      weight_i,
  input  logic [7:0]      diameter_i,
  output crc_pkg::class_t class_o
);
  import crc_pkg::*;

  logic [TYPE_SLOTS-1:0] in_win;

  always_comb begin
    for (int j = 0; j < TYPE_SLOTS; j++) begin
      in_win[j] = (j < CoinTypes) &&
                  (weight_i >= W_LO[j]) && (weight_i <= W_HI[j]) &&
                  (diameter_i >= D_LO[j]) && (diameter_i <= D_HI[j]);
    end
  end

  // Last matching type wins
  always_comb begin
    class_o = '0;
    for (int j = 0; j < TYPE_SLOTS; j++) begin
      if (in_win[j]) begin
        class_o.hit = 1'b1;
        class_o.idx = IDX_W'(j);
      end
    end
  end

endmodule

// File: rtl/coin_classify_and_route_core.sv
`timescale 1ns / 1ps
// Top level: coin classifier, wrapper/container router and statistics.
//
//  channel   dir   handshake              word
//  coin_i    in    valid/ready            coin_in_t: weight, diameter, bent, image
//  result_o  out   valid/ready            coin_res_t: destination and counters
//  apb       in    psel/penable/pwrite    roll sizes, container limits
//
// One coin per cycle sustained while result_o keeps taking words; the result
// register loads as a coin leaves the update stage.
// Accept edge: classify and read the wrapper memory into the update stage. Update
// stage: update wrapper or container state, write back, load result register.
// The wrapper memory is one port per direction with a registered read; a
// write at the same edge as the read is forwarded. Reset clears the control
// flags, the container and statistics counters and the per-entry valid bits
// of the wrapper memory (an invalid entry reads as zero), so no clearing pass
// is needed. A stalled result holds the update stage, which holds coin_i.ready low.
module coin_classify_and_route_core #(
  parameter int unsigned COIN_TYPES = crc_pkg::COIN_TYPES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  crc_chan_if.sink                    coin_i,
  crc_chan_if.source                  result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crc_pkg::APB_AW-1:0]  paddr,
  input  logic [crc_pkg::APB_DW-1:0]  pwdata,
  output logic [crc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import crc_pkg::*;

  localparam int unsigned AddrW = (COIN_TYPES > 1) ? $clog2(COIN_TYPES) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [5:0]  roll_size_q [KNOWN_TYPES];
  logic [15:0] bent_limit_q;
  logic [15:0] other_limit_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KNOWN_TYPES; i++) roll_size_q[i] <= ROLL_RESET[i];
      bent_limit_q  <= BENT_LIMIT_RESET;
      other_limit_q <= OTHER_LIMIT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROLL_NICKEL, REG_ROLL_DIME, REG_ROLL_QUARTER,
        REG_ROLL_LOONIE, REG_ROLL_TOONIE: roll_size_q[cfg_idx] <= pwdata[5:0];
        REG_BENT_LIMIT:  bent_limit_q  <= pwdata[15:0];
        REG_OTHER_LIMIT: other_limit_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROLL_NICKEL, REG_ROLL_DIME, REG_ROLL_QUARTER,
      REG_ROLL_LOONIE, REG_ROLL_TOONIE: prdata = APB_DW'(roll_size_q[cfg_idx]);
      REG_BENT_LIMIT:  prdata = APB_DW'(bent_limit_q);
      REG_OTHER_LIMIT: prdata = APB_DW'(other_limit_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake control
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv;
  logic in_acc;

  // Result register frees when empty or being taken; update stage advances then
  assign s1_adv       = s1_valid_q && (!out_valid_q || result_o.ready);
  assign coin_i.ready = !s1_valid_q || s1_adv;
  assign in_acc       = coin_i.valid && coin_i.ready;
  assign result_o.valid = out_valid_q;

  // ---------------------------------------------------------------------------
  // Stage 0: classify and route decision
  // ---------------------------------------------------------------------------
  class_t     cls;
  logic [2:0] dest0;

  crc_classify #(.CoinTypes(COIN_TYPES)) u_classify (
    .weight_i   (coin_i.data.weight_reading),
    .diameter_i (coin_i.data.diameter_reading),
    .class_o    (cls)
  );

  always_comb begin
    if (coin_i.data.is_bent) begin
      dest0 = DEST_BENT;
    end else if (!cls.hit || coin_i.data.image_match != IMG_BOTH) begin
      dest0 = DEST_OTHER;
    end else begin
      dest0 = cls.idx;
    end
  end

  logic [2:0]       s1_dest_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic [7:0]       s1_w_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_dest_q <= dest0;
      s1_idx_q  <= cls.idx;
      s1_w_q    <= coin_i.data.weight_reading;
    end
  end

  // ---------------------------------------------------------------------------
  // Wrapper memory: fill count and roll count per coin type
  // ---------------------------------------------------------------------------
  wrap_t                 wmem [COIN_TYPES];
  logic [COIN_TYPES-1:0] wvld_q;
  logic [AddrW-1:0]      rd_addr;
  logic [AddrW-1:0]      wr_addr;
  logic                  wr_en;
  wrap_t                 wr_data;
  wrap_t                 rd_data_q;
  logic                  rd_vld_q;
  logic                  fwd_hit_q;
  wrap_t                 fwd_data_q;
  wrap_t                 entry;

  assign rd_addr = cls.idx[AddrW-1:0];
  assign wr_addr = s1_idx_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) wmem[wr_addr] <= wr_data;
    if (in_acc) begin
      rd_data_q  <= wmem[rd_addr];
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q    <= '0;
      rd_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (wr_en) wvld_q[wr_addr] <= 1'b1;
      if (in_acc) begin
        rd_vld_q  <= wvld_q[rd_addr];
        // The previous coin writes at the same edge this one reads: forward it
        fwd_hit_q <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (fwd_hit_q)     entry = fwd_data_q;
    else if (rd_vld_q) entry = rd_data_q;
    else               entry = '0;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: update state and build result
  // ---------------------------------------------------------------------------
  logic [16:0] bent_w_q,  bent_w_d;
  logic [16:0] oth_w_q,   oth_w_d;
  logic [15:0] oth_cnt_q, oth_cnt_d;
  logic [15:0] oth_fill_q, oth_fill_d;
  logic [15:0] oth_cur_q, oth_cur_d;
  logic [31:0] oth_tot_q, oth_tot_d;

  logic [16:0] cont_sum;
  logic [32:0] tot_sum;
  logic [6:0]  fill_inc;
  logic [5:0]  rsize;
  coin_res_t   res_d;
  coin_res_t   res_q;

  always_comb begin
    if (s1_idx_q < IDX_W'(KNOWN_TYPES)) rsize = roll_size_q[s1_idx_q];
    else                                rsize = 6'd1;
  end

  always_comb begin
    bent_w_d   = bent_w_q;
    oth_w_d    = oth_w_q;
    oth_cnt_d  = oth_cnt_q;
    oth_fill_d = oth_fill_q;
    oth_cur_d  = oth_cur_q;
    oth_tot_d  = oth_tot_q;
    wr_en      = 1'b0;
    wr_data    = entry;
    res_d      = '0;
    res_d.destination = s1_dest_q;
    cont_sum   = '0;
    tot_sum    = 33'(oth_tot_q) + 33'(s1_w_q);
    fill_inc   = 7'(entry.fill) + 7'd1;

    case (s1_dest_q)
      DEST_BENT: begin
        cont_sum = bent_w_q + 17'(s1_w_q);
        if (cont_sum > 17'(bent_limit_q)) begin
          bent_w_d = 17'(s1_w_q);
          res_d.container_replaced = 1'b1;
        end else begin
          bent_w_d = cont_sum;
        end
        res_d.container_weight = bent_w_d;
      end
      DEST_OTHER: begin
        oth_tot_d = tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
        oth_cnt_d = sat_inc16(oth_cnt_q);
        cont_sum  = oth_w_q + 17'(s1_w_q);
        if (cont_sum > 17'(other_limit_q)) begin
          oth_w_d    = 17'(s1_w_q);
          oth_cur_d  = 16'd1;
          oth_fill_d = sat_inc16(oth_fill_q);
          res_d.container_replaced = 1'b1;
        end else begin
          oth_w_d   = cont_sum;
          oth_cur_d = sat_inc16(oth_cur_q);
        end
        res_d.container_weight = oth_w_d;
      end
      default: begin
        // Wrapper coin: advance fill, wrap and count a roll when full
        wr_en = s1_adv;
        if (fill_inc < 7'(rsize)) begin
          wr_data.fill = fill_inc[5:0];
        end else begin
          wr_data.fill  = '0;
          wr_data.rolls = sat_inc16(entry.rolls);
          res_d.roll_completed = 1'b1;
        end
        res_d.wrapper_fill  = wr_data.fill;
        res_d.rolls_of_type = wr_data.rolls;
      end
    endcase

    res_d.other_coin_total        = oth_cnt_d;
    res_d.other_containers_filled = oth_fill_d;
    res_d.other_in_current        = oth_cur_d;
    res_d.other_weight_total      = oth_tot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      bent_w_q    <= '0;
      oth_w_q     <= '0;
      oth_cnt_q   <= '0;
      oth_fill_q  <= '0;
      oth_cur_q   <= '0;
      oth_tot_q   <= '0;
    end else begin
      if (in_acc)      s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;

      if (s1_adv)               out_valid_q <= 1'b1;
      else if (result_o.ready)  out_valid_q <= 1'b0;

      if (s1_adv) begin
        bent_w_q   <= bent_w_d;
        oth_w_q    <= oth_w_d;
        oth_cnt_q  <= oth_cnt_d;
        oth_fill_q <= oth_fill_d;
        oth_cur_q  <= oth_cur_d;
        oth_tot_q  <= oth_tot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) res_q <= res_d;
  end

  assign result_o.data = res_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_roll_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.roll_completed) |-> (res_q.wrapper_fill == 6'd0))
    else $error("completed roll left a nonzero wrapper fill");

  a_container_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.destination == DEST_BENT || res_q.destination == DEST_OTHER))
      |-> (res_q.wrapper_fill == 6'd0 && !res_q.roll_completed &&
           res_q.rolls_of_type == 16'd0))
    else $error("container coin carries wrapper fields");

  a_replace_holds_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.container_replaced) |-> (res_q.container_weight <= 17'd255))
    else $error("new container holds more than one coin");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_dest_q) && !$past(in_acc)))
    else $error("update stage lost or replaced a stalled coin");

endmodule

// File: dv/coin_classify_and_route_core_tb.sv
`timescale 1ns / 1ps
// Testbench: coin classifier/router core checked against a cycle-free routing ledger.

package coin_route_tb_pkg;
  import crc_pkg::*;

  localparam int TYPES_KNOWN = 5;

  // Image-match codes other than a full match
  localparam logic [1:0] IMG_ONE     = 2'd1;
  localparam logic [1:0] IMG_NONE    = 2'd2;
  localparam logic [1:0] IMG_UNKNOWN = 2'd3;

  // Acceptance windows in raw counts, inclusive
  localparam int WIN_W_LO [TYPES_KNOWN] = '{92, 34, 102, 166, 173};
  localparam int WIN_W_HI [TYPES_KNOWN] = '{109, 56, 122, 191, 200};
  localparam int WIN_D_LO [TYPES_KNOWN] = '{87, 63, 109, 128, 144};
  localparam int WIN_D_HI [TYPES_KNOWN] = '{100, 73, 124, 144, 162};
  localparam int ROLL_DEFAULT [TYPES_KNOWN] = '{40, 50, 40, 25, 25};

  class route_ledger;
    int        roll_size [TYPES_KNOWN];
    int        bent_cap;
    int        other_cap;
    int        wrap_fill [TYPES_KNOWN];
    int        rolls [TYPES_KNOWN];
    int        bent_load;
    int        other_load;
    int        other_tally;
    int        other_swaps;
    int        other_now;
    longint    other_mass;
    coin_res_t pending_routes [$];
    int        fault_count;

    function new();
      foreach (roll_size[i]) begin
        roll_size[i] = ROLL_DEFAULT[i];
        wrap_fill[i] = 0;
        rolls[i]     = 0;
      end
      bent_cap    = 2550;
      other_cap   = 5100;
      bent_load   = 0;
      other_load  = 0;
      other_tally = 0;
      other_swaps = 0;
      other_now   = 0;
      other_mass  = 0;
      fault_count = 0;
    endfunction

    function int outstanding();
      return pending_routes.size();
    endfunction

    function int sat_up16(int v);
      return (v >= 65535) ? 65535 : v + 1;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_ROLL_NICKEL:  roll_size[0] = int'(v[5:0]);
        REG_ROLL_DIME:    roll_size[1] = int'(v[5:0]);
        REG_ROLL_QUARTER: roll_size[2] = int'(v[5:0]);
        REG_ROLL_LOONIE:  roll_size[3] = int'(v[5:0]);
        REG_ROLL_TOONIE:  roll_size[4] = int'(v[5:0]);
        REG_BENT_LIMIT:   bent_cap     = int'(v[15:0]);
        REG_OTHER_LIMIT:  other_cap    = int'(v[15:0]);
        default: ;
      endcase
    endfunction

    // Route one accepted coin and queue the word it must produce.
    task log_coin(input coin_in_t c);
      coin_res_t r;
      int        kind;
      int        w;
      int        d;
      int        sum;
      longint    mass;
      r    = '0;
      kind = -1;
      w    = int'(c.weight_reading);
      d    = int'(c.diameter_reading);
      // last matching window wins
      for (int t = 0; t < COIN_TYPES_DEF && t < TYPES_KNOWN; t++) begin
        if (w >= WIN_W_LO[t] && w <= WIN_W_HI[t] && d >= WIN_D_LO[t] && d <= WIN_D_HI[t])
          kind = t;
      end
      if (c.is_bent) begin
        r.destination = DEST_BENT;
        sum = bent_load + w;
        if (sum > bent_cap) begin
          bent_load = w;
          r.container_replaced = 1'b1;
        end else begin
          bent_load = sum;
        end
        r.container_weight = bent_load[16:0];
      end else if (kind < 0 || c.image_match != IMG_BOTH) begin
        r.destination = DEST_OTHER;
        mass = other_mass + w;
        other_mass  = (mass > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : mass;
        other_tally = sat_up16(other_tally);
        sum = other_load + w;
        if (sum > other_cap) begin
          other_load  = w;
          other_now   = 1;
          other_swaps = sat_up16(other_swaps);
          r.container_replaced = 1'b1;
        end else begin
          other_load = sum;
          other_now  = sat_up16(other_now);
        end
        r.container_weight = other_load[16:0];
      end else begin
        r.destination = kind[2:0];
        sum = wrap_fill[kind] + 1;
        if (sum < roll_size[kind]) begin
          wrap_fill[kind] = sum;
        end else begin
          wrap_fill[kind] = 0;
          rolls[kind]     = sat_up16(rolls[kind]);
          r.roll_completed = 1'b1;
        end
        r.wrapper_fill  = wrap_fill[kind][5:0];
        r.rolls_of_type = rolls[kind][15:0];
      end
      r.other_coin_total        = other_tally[15:0];
      r.other_containers_filled = other_swaps[15:0];
      r.other_in_current        = other_now[15:0];
      r.other_weight_total      = other_mass[31:0];
      pending_routes.push_back(r);
    endtask

    task flag_fault(input string msg);
      fault_count++;
      $display("[%0t] route check failed: %s", $time, msg);
    endtask

    task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
        flag_fault($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // Compare one delivered word with the oldest expected route.
    task check_routing(input coin_res_t got);
      coin_res_t want;
      if (pending_routes.size() == 0) begin
        flag_fault($sformatf("result word with nothing outstanding, dest %0d",
                             got.destination));
        return;
      end
      want = pending_routes.pop_front();
      check_field("destination", 32'(got.destination), 32'(want.destination));
      check_field("wrapper_fill", 32'(got.wrapper_fill), 32'(want.wrapper_fill));
      check_field("roll_completed", 32'(got.roll_completed), 32'(want.roll_completed));
      check_field("rolls_of_type", 32'(got.rolls_of_type), 32'(want.rolls_of_type));
      check_field("container_weight", 32'(got.container_weight),
                  32'(want.container_weight));
      check_field("container_replaced", 32'(got.container_replaced),
                  32'(want.container_replaced));
      check_field("other_coin_total", 32'(got.other_coin_total),
                  32'(want.other_coin_total));
      check_field("other_containers_filled", 32'(got.other_containers_filled),
                  32'(want.other_containers_filled));
      check_field("other_in_current", 32'(got.other_in_current),
                  32'(want.other_in_current));
      check_field("other_weight_total", got.other_weight_total, want.other_weight_total);
    endtask
  endclass

endpackage

module coin_classify_and_route_core_tb;
  import crc_pkg::*;
  import coin_route_tb_pkg::*;

  localparam int HOLD_CYCLES = 64;
  localparam logic [2:0] REG_ORDER [7] = '{REG_ROLL_NICKEL, REG_ROLL_DIME, REG_ROLL_QUARTER,
                                           REG_ROLL_LOONIE, REG_ROLL_TOONIE, REG_BENT_LIMIT,
                                           REG_OTHER_LIMIT};

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bit src_gaps;
  bit sink_gaps;
  bit hold_off;

  route_ledger ledger = new();

  crc_chan_if #(.T(coin_in_t))  coin_if ();
  crc_chan_if #(.T(coin_res_t)) res_if ();

  coin_classify_and_route_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .coin_i   (coin_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("coin_classify_and_route_core: mismatch");
    $finish;
  end

  // Log accepted coins and check delivered words at the edge they move on.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready)
        ledger.check_routing(res_if.data);
      if (coin_if.valid && coin_if.ready)
        ledger.log_coin(coin_if.data);
    end
  end

  // Result side: ready with random stall bursts, plus one long hold-off on request.
  initial begin
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic coin_in_t make_coin(int w, int d, bit bent, logic [1:0] img);
    coin_in_t c;
    c.weight_reading   = w[7:0];
    c.diameter_reading = d[7:0];
    c.is_bent          = bent;
    c.image_match      = img;
    return c;
  endfunction

  // Mostly well-formed coins inside a window, the rest raw noise.
  function automatic coin_in_t random_coin();
    coin_in_t c;
    int       t;
    if ($urandom_range(0, 99) < 65) begin
      t = $urandom_range(0, TYPES_KNOWN - 1);
      c.weight_reading   = 8'($urandom_range(WIN_W_LO[t], WIN_W_HI[t]));
      c.diameter_reading = 8'($urandom_range(WIN_D_LO[t], WIN_D_HI[t]));
      c.is_bent          = ($urandom_range(0, 9) == 0);
      c.image_match      = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(1, 3)) : IMG_BOTH;
    end else begin
      c.weight_reading   = 8'($urandom_range(0, 255));
      c.diameter_reading = 8'($urandom_range(0, 255));
      c.is_bent          = 1'($urandom_range(0, 1));
      c.image_match      = 2'($urandom_range(0, 3));
    end
    return c;
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_coin(input coin_in_t c);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      coin_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    coin_if.valid <= 1'b1;
    coin_if.data  <= c;
    do @(posedge clk_i); while (!coin_if.ready);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_coin(random_coin());
  endtask

  // Stop offering and wait until every expected word has been delivered.
  task automatic settle();
    coin_if.valid <= 1'b0;
    do @(negedge clk_i); while (ledger.outstanding() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all seven registers back to back; access phase completes on pready.
  task automatic load_settings(input int sizes[5], input int bent_cap, input int other_cap);
    logic [31:0] v;
    for (int k = 0; k < 7; k++) begin
      case (REG_ORDER[k])
        REG_BENT_LIMIT:  v = bent_cap;
        REG_OTHER_LIMIT: v = other_cap;
        default:         v = sizes[k];
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_ORDER[k], 2'b00};
      pwdata  <= v;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      ledger.set_register(REG_ORDER[k], v);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int sizes[5];
    rst_ni        <= 1'b0;
    coin_if.valid <= 1'b0;
    coin_if.data  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    hold_off  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: every type, window corners, the loonie/toonie overlap,
    // near misses, field extremes, bent precedence and each image code.
    send_coin(make_coin(100, 93, 1'b0, IMG_BOTH));
    send_coin(make_coin(45, 68, 1'b0, IMG_BOTH));
    send_coin(make_coin(112, 116, 1'b0, IMG_BOTH));
    send_coin(make_coin(178, 136, 1'b0, IMG_BOTH));
    send_coin(make_coin(186, 153, 1'b0, IMG_BOTH));
    send_coin(make_coin(180, 144, 1'b0, IMG_BOTH));
    send_coin(make_coin(92, 87, 1'b0, IMG_BOTH));
    send_coin(make_coin(109, 100, 1'b0, IMG_BOTH));
    send_coin(make_coin(34, 63, 1'b0, IMG_BOTH));
    send_coin(make_coin(56, 73, 1'b0, IMG_BOTH));
    send_coin(make_coin(102, 109, 1'b0, IMG_BOTH));
    send_coin(make_coin(122, 124, 1'b0, IMG_BOTH));
    send_coin(make_coin(200, 162, 1'b0, IMG_BOTH));
    send_coin(make_coin(91, 87, 1'b0, IMG_BOTH));
    send_coin(make_coin(201, 162, 1'b0, IMG_BOTH));
    send_coin(make_coin(0, 0, 1'b0, IMG_BOTH));
    send_coin(make_coin(255, 255, 1'b0, IMG_UNKNOWN));
    send_coin(make_coin(100, 93, 1'b1, IMG_BOTH));
    send_coin(make_coin(45, 68, 1'b0, IMG_ONE));
    send_coin(make_coin(112, 116, 1'b0, IMG_NONE));
    send_coin(make_coin(178, 136, 1'b0, IMG_UNKNOWN));
    settle();

    // Zero-capacity containers and a zero loonie roll size: every coin of nonzero
    // weight replaces its container, every loonie completes a roll.
    load_settings('{3, 1, 2, 0, 5}, 0, 0);
    send_coin(make_coin(255, 0, 1'b1, IMG_BOTH));
    send_coin(make_coin(0, 0, 1'b1, IMG_NONE));
    send_coin(make_coin(178, 136, 1'b0, IMG_BOTH));
    send_coin(make_coin(178, 136, 1'b0, IMG_BOTH));
    send_coin(make_coin(45, 68, 1'b0, IMG_BOTH));
    send_random(300);
    settle();

    // Widest settings; midway, hold the result side off so the block backs up.
    load_settings('{63, 63, 63, 63, 63}, 65535, 65535);
    send_random(200);
    hold_off = 1'b1;
    send_random(200);
    settle();

    // Lower roll sizes below the fills built up above.
    load_settings('{2, 7, 1, 4, 10}, 2550, 5100);
    send_random(400);
    settle();

    // No idling on either side from here on.
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;

    // Closing random stretch under random settings.
    foreach (sizes[i]) sizes[i] = $urandom_range(1, 63);
    load_settings(sizes, $urandom_range(0, 3000), $urandom_range(0, 3000));
    send_random(450);
    settle();
    repeat (4) @(posedge clk_i);

    if (ledger.fault_count == 0 && ledger.outstanding() == 0) begin
      $display("coin_classify_and_route_core: match");
    end else begin
      $display("coin_classify_and_route_core: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/crc_pkg.sv
rtl/crc_chan_if.sv
rtl/crc_classify.sv
rtl/coin_classify_and_route_core.sv
dv/coin_classify_and_route_core_tb.sv
